>>> hdl/dqcp_pkg.sv
// dqcp_pkg: beat types, channel control struct and pole codes for the
// dual quadrature counter; no dependencies
`default_nettype none

package dqcp_pkg;

   localparam int unsigned CountWidth = 32;
   localparam int unsigned StepWidth  = 16;

   localparam logic [StepWidth-1:0] STEP_RESET = 16'd100;

   // pole state packs a in bit 1 and b in bit 0
   localparam logic [1:0] POLES_00 = 2'b00;
   localparam logic [1:0] POLES_01 = 2'b01;
   localparam logic [1:0] POLES_10 = 2'b10;
   localparam logic [1:0] POLES_11 = 2'b11;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic cmd;
      logic left_a;
      logic left_b;
      logic right_a;
      logic right_b;
   } dqcp_req_type;

   typedef struct packed {
      logic signed [CountWidth-1:0] left_count;
      logic signed [CountWidth-1:0] right_count;
      logic        [CountWidth-1:0] left_period;
      logic        [CountWidth-1:0] right_period;
   } dqcp_rsp_type;

   typedef struct packed {
      logic       sample;
      logic       clear;
      logic [1:0] poles;
   } dqcp_chan_ctl_type;

endpackage

`default_nettype wire

>>> hdl/dual_quadrature_counter_period.sv
// dual_quadrature_counter_period: left and right quadrature counters with
// period capture; a req beat passes through the input register and then the
// result register before it shows on rsp; one beat per cycle sustained while
// rsp_ready holds, set by the input register and the result register.
// reset (synchronous) zeroes time, counts, edge times and periods and sets
// the tick step to 100; uses dqcp_pkg and dqcp_channel
`default_nettype none

module dual_quadrature_counter_period
   import dqcp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dqcp_req_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output dqcp_rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [StepWidth-1:0] csr_data
);

   logic                  s1_valid_ff;
   dqcp_req_type          s1_ff;
   logic                  rsp_valid_ff;
   dqcp_rsp_type          rsp_data_ff;
   logic [StepWidth-1:0]  step_ff;
   logic [CountWidth-1:0] free_time_ff, free_time_in;
   logic                  move;
   logic                  tick;
   dqcp_chan_ctl_type     left_ctl, right_ctl;
   logic [CountWidth-1:0] left_pos_in, right_pos_in, left_per_in, right_per_in;

   // stage 1 beat moves into the result register when that one is free or drained
   assign move      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || move;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign tick         = move && (s1_ff.cmd == CMD_TICK);
   assign free_time_in = tick ? free_time_ff + {{(CountWidth-StepWidth){1'b0}}, step_ff}
                              : free_time_ff;

   always_comb begin
      left_ctl.sample  = tick;
      left_ctl.clear   = move && (s1_ff.cmd == CMD_CLEAR);
      left_ctl.poles   = {s1_ff.left_a, s1_ff.left_b};
      right_ctl.sample = tick;
      right_ctl.clear  = move && (s1_ff.cmd == CMD_CLEAR);
      right_ctl.poles  = {s1_ff.right_a, s1_ff.right_b};
   end

   dqcp_channel u_left (
      .clock       (clock),
      .reset       (reset),
      .ctl         (left_ctl),
      .time_now    (free_time_in),
      .position_in (left_pos_in),
      .period_in   (left_per_in)
   );

   dqcp_channel u_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (right_ctl),
      .time_now    (free_time_in),
      .position_in (right_pos_in),
      .period_in   (right_per_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_RESET;
         free_time_ff <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            step_ff <= csr_data;
         end
         free_time_ff <= free_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff.left_count   <= left_pos_in;
         rsp_data_ff.right_count  <= right_pos_in;
         rsp_data_ff.left_period  <= left_per_in;
         rsp_data_ff.right_period <= right_per_in;
      end
   end

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      move && (s1_ff.cmd == CMD_CLEAR) |=>
         (rsp_data_ff.left_count == 0) && (rsp_data_ff.right_count == 0))
      else $error("clear beat did not zero both counts");

   a_time_holds: assert property (@(posedge clock) disable iff (reset)
      !tick |=> $stable(free_time_ff))
      else $error("free time moved without a tick beat");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("beat moved but no result shown");

endmodule

`default_nettype wire

>>> hdl/dqcp_channel.sv
// dqcp_channel: one encoder channel, holds pole state, position, edge time
// and period; uses dqcp_pkg
`default_nettype none

module dqcp_channel
   import dqcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dqcp_chan_ctl_type     ctl,
   input  wire logic [CountWidth-1:0] time_now,
   output logic      [CountWidth-1:0] position_in,
   output logic      [CountWidth-1:0] period_in
);

   logic [1:0]            poles_ff,  poles_in;
   logic [CountWidth-1:0] pos_ff;
   logic [CountWidth-1:0] edge_ff,   edge_in;
   logic [CountWidth-1:0] period_ff;

   always_comb begin
      poles_in    = poles_ff;
      position_in = pos_ff;
      edge_in     = edge_ff;
      period_in   = period_ff;
      if (ctl.clear) begin
         position_in = '0;
      end else if (ctl.sample) begin
         poles_in = ctl.poles;
         case (poles_ff)
            POLES_00: begin
               if (ctl.poles inside {POLES_10, POLES_01}) begin
                  position_in = (ctl.poles == POLES_10) ? pos_ff + 32'd1 : pos_ff - 32'd1;
                  period_in   = time_now - edge_ff;
                  edge_in     = time_now;
               end
            end
            POLES_11: begin
               if (ctl.poles == POLES_01) begin
                  position_in = pos_ff + 32'd1;
               end else if (ctl.poles == POLES_10) begin
                  position_in = pos_ff - 32'd1;
               end
            end
            default: begin
               // moves out of 10 or 01 leave the count alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poles_ff  <= POLES_00;
         pos_ff    <= '0;
         edge_ff   <= '0;
         period_ff <= '0;
      end else begin
         poles_ff  <= poles_in;
         pos_ff    <= position_in;
         edge_ff   <= edge_in;
         period_ff <= period_in;
      end
   end

endmodule

`default_nettype wire
